// File: rtl/ils_pkg.sv
// Shared constants, types and status codes of the 2x2 integer solver.
package ils_pkg;

  localparam int COEF_BITS   = 10;
  localparam int TARGET_BITS = 47;
  localparam int OUT_BITS    = 58;
  localparam int NUM_W       = TARGET_BITS + COEF_BITS;
  localparam int DEN_W       = 2 * COEF_BITS;
  localparam int REM_W       = DEN_W + 1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_DEGEN = 2'd2
  } status_t;

  // Everything one divider stage hands to the next.
  typedef struct packed {
    logic             valid;
    logic             dzero;
    logic             sign_bad;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem_a;
    logic [DEN_W-1:0] rem_b;
    logic [NUM_W-1:0] nq_a;
    logic [NUM_W-1:0] nq_b;
  } div_stage_t;

endpackage

// File: rtl/ils_front.sv
// Front end: cross products, then signed differences as magnitude and sign.
module ils_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic [ils_pkg::COEF_BITS-1:0]    x1,
  input  logic [ils_pkg::COEF_BITS-1:0]    y1,
  input  logic [ils_pkg::COEF_BITS-1:0]    x2,
  input  logic [ils_pkg::COEF_BITS-1:0]    y2,
  input  logic [ils_pkg::TARGET_BITS-1:0]  tx,
  input  logic [ils_pkg::TARGET_BITS-1:0]  ty,
  output ils_pkg::div_stage_t              stage_o
);
  import ils_pkg::*;

  logic             v1_r;
  logic [DEN_W-1:0] pd1_r, pd2_r;
  logic [NUM_W-1:0] pa1_r, pa2_r, pb1_r, pb2_r;
  div_stage_t       st_r;
  div_stage_t       st_nxt;
  logic             dneg, aneg, bneg;
  logic [DEN_W-1:0] dmag;
  logic [NUM_W-1:0] amag, bmag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
    pd1_r <= DEN_W'(x1) * DEN_W'(y2);
    pd2_r <= DEN_W'(x2) * DEN_W'(y1);
    pa1_r <= NUM_W'(tx) * NUM_W'(y2);
    pa2_r <= NUM_W'(ty) * NUM_W'(x2);
    pb1_r <= NUM_W'(ty) * NUM_W'(x1);
    pb2_r <= NUM_W'(tx) * NUM_W'(y1);
  end

  always_comb begin
    dneg = pd2_r > pd1_r;
    dmag = dneg ? pd2_r - pd1_r : pd1_r - pd2_r;
    aneg = pa2_r > pa1_r;
    amag = aneg ? pa2_r - pa1_r : pa1_r - pa2_r;
    bneg = pb2_r > pb1_r;
    bmag = bneg ? pb2_r - pb1_r : pb1_r - pb2_r;
    st_nxt.valid    = v1_r;
    st_nxt.dzero    = (dmag == '0);
    // A nonzero numerator whose sign differs from the determinant's gives a
    // negative quotient.
    st_nxt.sign_bad = ((amag != '0) && (aneg != dneg)) ||
                      ((bmag != '0) && (bneg != dneg));
    st_nxt.den      = dmag;
    st_nxt.rem_a    = '0;
    st_nxt.rem_b    = '0;
    st_nxt.nq_a     = amag;
    st_nxt.nq_b     = bmag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_nxt.valid;
    end
    st_r.dzero    <= st_nxt.dzero;
    st_r.sign_bad <= st_nxt.sign_bad;
    st_r.den      <= st_nxt.den;
    st_r.rem_a    <= st_nxt.rem_a;
    st_r.rem_b    <= st_nxt.rem_b;
    st_r.nq_a     <= st_nxt.nq_a;
    st_r.nq_b     <= st_nxt.nq_b;
  end

  assign stage_o = st_r;

endmodule

// File: rtl/ils_cell.sv
// One restoring-division cell: produces one quotient bit for both numerators.
module ils_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ils_pkg::div_stage_t stage_i,
  output ils_pkg::div_stage_t stage_o
);
  import ils_pkg::*;

  div_stage_t       st_r;
  div_stage_t       st_nxt;
  logic [REM_W-1:0] sh_a, sh_b, dext;
  logic             ge_a, ge_b;

  always_comb begin
    // The numerator shifts out at the top while quotient bits fill the bottom.
    dext  = {1'b0, stage_i.den};
    sh_a  = {stage_i.rem_a, stage_i.nq_a[NUM_W-1]};
    sh_b  = {stage_i.rem_b, stage_i.nq_b[NUM_W-1]};
    ge_a  = sh_a >= dext;
    ge_b  = sh_b >= dext;
    st_nxt = stage_i;
    st_nxt.rem_a = ge_a ? DEN_W'(sh_a - dext) : DEN_W'(sh_a);
    st_nxt.rem_b = ge_b ? DEN_W'(sh_b - dext) : DEN_W'(sh_b);
    st_nxt.nq_a  = {stage_i.nq_a[NUM_W-2:0], ge_a};
    st_nxt.nq_b  = {stage_i.nq_b[NUM_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_nxt.valid;
    end
    st_r.dzero    <= st_nxt.dzero;
    st_r.sign_bad <= st_nxt.sign_bad;
    st_r.den      <= st_nxt.den;
    st_r.rem_a    <= st_nxt.rem_a;
    st_r.rem_b    <= st_nxt.rem_b;
    st_r.nq_a     <= st_nxt.nq_a;
    st_r.nq_b     <= st_nxt.nq_b;
  end

  assign stage_o = st_r;

endmodule

// File: rtl/integer_2x2_linear_solve_top.sv
// Top level of the pipelined 2x2 integer solver by Cramer's rule.
// The solver takes one transaction every clock cycle; busy is always low.
// Each result reaches out_valid through a register of products, a register of
// signed differences, a chain of division cells that each yield one quotient
// bit per numerator, and an output register. Results arrive in order and must
// be taken when out_valid is high.
module integer_2x2_linear_solve_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ils_pkg::COEF_BITS-1:0]   in_col1_x,
  input  logic [ils_pkg::COEF_BITS-1:0]   in_col1_y,
  input  logic [ils_pkg::COEF_BITS-1:0]   in_col2_x,
  input  logic [ils_pkg::COEF_BITS-1:0]   in_col2_y,
  input  logic [ils_pkg::TARGET_BITS-1:0] in_target_x,
  input  logic [ils_pkg::TARGET_BITS-1:0] in_target_y,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [ils_pkg::OUT_BITS-1:0]    out_solution_a,
  output logic [ils_pkg::OUT_BITS-1:0]    out_solution_b
);
  import ils_pkg::*;

  localparam int LAT = NUM_W + 3;

  div_stage_t            chain [NUM_W+1];
  logic                  acc;
  logic                  valid_r;
  status_t               status_r, status_nxt;
  logic [OUT_BITS-1:0]   sol_a_r, sol_b_r, sol_a_nxt, sol_b_nxt;
  div_stage_t            last;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  ils_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .x1      (in_col1_x),
    .y1      (in_col1_y),
    .x2      (in_col2_x),
    .y2      (in_col2_y),
    .tx      (in_target_x),
    .ty      (in_target_y),
    .stage_o (chain[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    ils_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  assign last = chain[NUM_W];

  always_comb begin
    sol_a_nxt = '0;
    sol_b_nxt = '0;
    if (last.dzero) begin
      status_nxt = ST_DEGEN;
    end else if (last.sign_bad || last.rem_a != '0 || last.rem_b != '0) begin
      status_nxt = ST_NONE;
    end else begin
      status_nxt = ST_OK;
      sol_a_nxt  = OUT_BITS'(last.nq_a);
      sol_b_nxt  = OUT_BITS'(last.nq_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= last.valid;
    end
    status_r <= status_nxt;
    sol_a_r  <= sol_a_nxt;
    sol_b_r  <= sol_b_nxt;
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_solution_a = sol_a_r;
  assign out_solution_b = sol_b_r;

`ifndef SYNTHESIS
  // Two-state so that samples from before the first clock read as idle.
  bit acc_live;
  assign acc_live = acc && rst_n;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(acc_live, LAT))
    else $error("result strobe does not match a start issued LAT cycles before");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DEGEN || out_status == ST_NONE) |->
    out_solution_a == '0 && out_solution_b == '0)
    else $error("failed solve reports nonzero multipliers");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    last.valid && last.dzero |=> out_status == ST_DEGEN)
    else $error("zero determinant not reported as degenerate");
`endif

endmodule
